>>> rtl/core/dcct_pkg.sv
// Shared types and constants for the donor-cell convection term block.
// Holds the transfer structs, register index codes and width helpers.
// No dependencies.
`timescale 1ns / 1ps

package dcct_pkg;

	// Stencil value width; fixes the transfer struct layout.
	localparam int DATA_WIDTH = 32;

	// Sums and differences of two stencil values.
	localparam int SUM_W = DATA_WIDTH + 1;
	// Product of two sums.
	localparam int PROD_W = 2 * SUM_W;
	// Difference of two products (central and donor terms).
	localparam int DIFF_W = PROD_W + 1;

	// Configuration register widths.
	localparam int INV_W = 32;
	localparam int WEIGHT_W = 17;
	localparam int WEIGHT_BITS = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 32;

	// Blended bracket before the final scaling shift.
	localparam int COMB_W = DIFF_W + WEIGHT_W + 1;

	// Register index codes.
	localparam logic [CFG_INDEX_W-1:0] REG_INV_DX = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_DY = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_UPWIND_WEIGHT = 2'd2;

	// Reset values.
	localparam logic [INV_W-1:0] INV_RESET = 32'd65536;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd0;

	// Mode select codes.
	localparam logic MODE_U = 1'b0;
	localparam logic MODE_V = 1'b1;

	// Width of the bracket after the shift by FRAC_BITS + WEIGHT_BITS + 2.
	function automatic int bracket_width(input int frac_bits);
		return COMB_W - (frac_bits + WEIGHT_BITS + 2);
	endfunction

	// Width of one axis part: signed bracket times unsigned reciprocal.
	function automatic int part_width(input int frac_bits);
		return bracket_width(frac_bits) + INV_W + 1;
	endfunction

	typedef struct packed {
		logic                         req_type;
		logic signed [DATA_WIDTH-1:0] m_center;
		logic signed [DATA_WIDTH-1:0] m_plus_own;
		logic signed [DATA_WIDTH-1:0] m_minus_own;
		logic signed [DATA_WIDTH-1:0] m_plus_cross;
		logic signed [DATA_WIDTH-1:0] m_minus_cross;
		logic signed [DATA_WIDTH-1:0] c_center;
		logic signed [DATA_WIDTH-1:0] c_plus_own;
		logic signed [DATA_WIDTH-1:0] c_minus_cross;
		logic signed [DATA_WIDTH-1:0] c_diag;
	} item_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] convection;
		logic                         saturated;
	} result_t;

	// Operands of one axis: two flux products s*t and two donor terms |s|*d.
	typedef struct packed {
		logic [SUM_W-1:0] s1;
		logic [SUM_W-1:0] t1;
		logic [SUM_W-1:0] d1;
		logic [SUM_W-1:0] s2;
		logic [SUM_W-1:0] t2;
		logic [SUM_W-1:0] d2;
	} axis_ops_t;

	// Control that travels with each item down an axis pipeline.
	typedef struct packed {
		logic valid;
		logic sel;
	} axis_ctl_t;

endpackage

>>> rtl/core/dcct_axis.sv
// One axis part of the convection term: products, blend, scale by 1/h.
// Six register stages; depends on dcct_pkg.
`timescale 1ns / 1ps

module dcct_axis #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  dcct_pkg::axis_ctl_t                                    ctl_in,
	input  dcct_pkg::axis_ops_t                                    ops,
	input  logic [dcct_pkg::INV_W-1:0]                             inv_a,
	input  logic [dcct_pkg::INV_W-1:0]                             inv_b,
	input  logic [dcct_pkg::WEIGHT_W-1:0]                          weight,
	output dcct_pkg::axis_ctl_t                                    ctl_out,
	output logic signed [dcct_pkg::part_width(FRAC_BITS)-1:0]      part
);

	localparam int SUM_W = dcct_pkg::SUM_W;
	localparam int PROD_W = dcct_pkg::PROD_W;
	localparam int DIFF_W = dcct_pkg::DIFF_W;
	localparam int COMB_W = dcct_pkg::COMB_W;
	localparam int INV_W = dcct_pkg::INV_W;
	localparam int WEIGHT_W = dcct_pkg::WEIGHT_W;
	localparam int WEIGHT_BITS = dcct_pkg::WEIGHT_BITS;
	localparam int SHIFT = FRAC_BITS + WEIGHT_BITS + 2;
	localparam int BRACKET_W = dcct_pkg::bracket_width(FRAC_BITS);
	localparam int PART_W = dcct_pkg::part_width(FRAC_BITS);
	// Donor split for the weight multiply.
	localparam int DLO_W = DIFF_W / 2;
	localparam int DHI_W = DIFF_W - DLO_W;
	// Bracket split for the reciprocal multiply.
	localparam int BLO_W = BRACKET_W / 2;
	localparam int BHI_W = BRACKET_W - BLO_W;

	dcct_pkg::axis_ctl_t ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;

	logic        [SUM_W-1:0]              abs1, abs2;
	logic signed [PROD_W-1:0]             flux1_s2, flux2_s2, don1_s2, don2_s2;
	logic signed [DIFF_W-1:0]             central_s3, donor_s3, central_s4;
	logic        [DLO_W+WEIGHT_W-1:0]     gw_lo_s4;
	logic signed [DHI_W+WEIGHT_W:0]       gw_hi_s4;
	logic signed [COMB_W-1:0]             comb;
	logic signed [BRACKET_W-1:0]          bracket_s5;
	logic        [INV_W-1:0]              inv_sel;
	logic        [BLO_W+INV_W-1:0]        pp_lo_s6;
	logic signed [BHI_W+INV_W:0]          pp_hi_s6;
	logic signed [PART_W-1:0]             part_s7;

	assign abs1 = ops.s1[SUM_W-1] ? SUM_W'(-$signed(ops.s1)) : ops.s1;
	assign abs2 = ops.s2[SUM_W-1] ? SUM_W'(-$signed(ops.s2)) : ops.s2;

	assign comb = (COMB_W'(central_s4) <<< WEIGHT_BITS)
		+ (COMB_W'(gw_hi_s4) <<< DLO_W)
		+ COMB_W'(gw_lo_s4);

	assign inv_sel = ctl_s5.sel ? inv_b : inv_a;

	// Advance the control alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else begin
			ctl_s2 <= ctl_in;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.valid) begin
			flux1_s2 <= $signed(ops.s1) * $signed(ops.t1);
			flux2_s2 <= $signed(ops.s2) * $signed(ops.t2);
			don1_s2  <= $signed({1'b0, abs1}) * $signed(ops.d1);
			don2_s2  <= $signed({1'b0, abs2}) * $signed(ops.d2);
		end
		if (ctl_s2.valid) begin
			central_s3 <= DIFF_W'(flux1_s2) - DIFF_W'(flux2_s2);
			donor_s3   <= DIFF_W'(don1_s2) - DIFF_W'(don2_s2);
		end
		if (ctl_s3.valid) begin
			central_s4 <= central_s3;
			gw_lo_s4   <= donor_s3[DLO_W-1:0] * weight;
			gw_hi_s4   <= $signed(donor_s3[DIFF_W-1:DLO_W]) * $signed({1'b0, weight});
		end
		if (ctl_s4.valid) begin
			// Floor division by 2^SHIFT: keep the upper bits.
			bracket_s5 <= comb[COMB_W-1:SHIFT];
		end
		if (ctl_s5.valid) begin
			pp_lo_s6 <= bracket_s5[BLO_W-1:0] * inv_sel;
			pp_hi_s6 <= $signed(bracket_s5[BRACKET_W-1:BLO_W]) * $signed({1'b0, inv_sel});
		end
		if (ctl_s6.valid) begin
			part_s7 <= (PART_W'(pp_hi_s6) <<< BLO_W) + PART_W'(pp_lo_s6);
		end
	end

	assign ctl_out = ctl_s7;
	assign part = part_s7;

endmodule

>>> rtl/core/donor_cell_convection_term_top.sv
// Path: a start transfer passes the stage 1 register, the axis unit stages and the stage 8 register to done.
// Throughput: one item per cycle; busy stays low, so start may be held every cycle.
// The depth is set by the product, blend and 1/h multiply stages of each axis unit.
// done is a one-cycle strobe; the receiver cannot stall the result.
// Reset (arst_n low) drops all items in flight and restores the register defaults.
// Depends on dcct_pkg and dcct_axis.
`timescale 1ns / 1ps

module donor_cell_convection_term_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// command channel
	input  logic                                start,
	output logic                                busy,
	input  dcct_pkg::item_t                     req,
	// result channel
	output logic                                done,
	output dcct_pkg::result_t                   result,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [dcct_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [dcct_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int DW = dcct_pkg::DATA_WIDTH;
	localparam int SUM_W = dcct_pkg::SUM_W;
	localparam int PART_W = dcct_pkg::part_width(FRAC_BITS);
	localparam int TOT_W = PART_W + 1;
	// start transfer to done strobe, in cycles
	localparam int PIPE_DEPTH = 8;

	localparam logic signed [DW-1:0] RES_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] RES_MIN = {1'b1, {(DW-1){1'b0}}};

	// ------------------------------------------------------------------
	// Configuration registers: take the write at once, drop unknown indexes.
	// ------------------------------------------------------------------
	logic [dcct_pkg::INV_W-1:0]    inv_dx_q, inv_dy_q;
	logic [dcct_pkg::WEIGHT_W-1:0] weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_dx_q <= dcct_pkg::INV_RESET;
			inv_dy_q <= dcct_pkg::INV_RESET;
			weight_q <= dcct_pkg::WEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dcct_pkg::REG_INV_DX:        inv_dx_q <= cfg_wdata[dcct_pkg::INV_W-1:0];
				dcct_pkg::REG_INV_DY:        inv_dy_q <= cfg_wdata[dcct_pkg::INV_W-1:0];
				dcct_pkg::REG_UPWIND_WEIGHT: weight_q <= cfg_wdata[dcct_pkg::WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// The pipeline never stalls, so a transfer is possible every cycle.
	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// Stage 1: form the stencil sums and differences for both axes.
	// ------------------------------------------------------------------
	logic                 take;
	logic [SUM_W-1:0]     mc, mpo, mmo, mpc, mmc, cc, cpo, cmc, cd;
	dcct_pkg::axis_ops_t  own_ops, cross_ops, own_ops_s1, cross_ops_s1;
	dcct_pkg::axis_ctl_t  ctl_s1, own_ctl, cross_ctl;

	assign take = start && !busy;

	// Sign-extend each value by one bit so the sums cannot wrap.
	assign mc  = SUM_W'(req.m_center);
	assign mpo = SUM_W'(req.m_plus_own);
	assign mmo = SUM_W'(req.m_minus_own);
	assign mpc = SUM_W'(req.m_plus_cross);
	assign mmc = SUM_W'(req.m_minus_cross);
	assign cc  = SUM_W'(req.c_center);
	assign cpo = SUM_W'(req.c_plus_own);
	assign cmc = SUM_W'(req.c_minus_cross);
	assign cd  = SUM_W'(req.c_diag);

	// Own axis: the main component carries itself.
	always_comb begin
		own_ops.s1 = mc + mpo;
		own_ops.t1 = mc + mpo;
		own_ops.d1 = mc - mpo;
		own_ops.s2 = mmo + mc;
		own_ops.t2 = mmo + mc;
		own_ops.d2 = mmo - mc;
	end

	// Cross axis: the averaged cross component carries the main one.
	always_comb begin
		cross_ops.s1 = cc + cpo;
		cross_ops.t1 = mc + mpc;
		cross_ops.d1 = mc - mpc;
		cross_ops.s2 = cmc + cd;
		cross_ops.t2 = mmc + mc;
		cross_ops.d2 = mmc - mc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= take;
			ctl_s1.sel   <= req.req_type;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			own_ops_s1   <= own_ops;
			cross_ops_s1 <= cross_ops;
		end
	end

	// ------------------------------------------------------------------
	// Stages 2 to 7: one axis unit per axis. In v mode the spacings swap,
	// so the own unit picks inv_dy and the cross unit inv_dx.
	// ------------------------------------------------------------------
	logic signed [PART_W-1:0] own_part, cross_part;

	dcct_axis #(
		.FRAC_BITS(FRAC_BITS)
	) u_own (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s1),
		.ops     (own_ops_s1),
		.inv_a   (inv_dx_q),
		.inv_b   (inv_dy_q),
		.weight  (weight_q),
		.ctl_out (own_ctl),
		.part    (own_part)
	);

	dcct_axis #(
		.FRAC_BITS(FRAC_BITS)
	) u_cross (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s1),
		.ops     (cross_ops_s1),
		.inv_a   (inv_dy_q),
		.inv_b   (inv_dx_q),
		.weight  (weight_q),
		.ctl_out (cross_ctl),
		.part    (cross_part)
	);

	// ------------------------------------------------------------------
	// Stage 8: add the parts, drop the fraction bits, clip to DW bits.
	// ------------------------------------------------------------------
	logic signed [TOT_W-1:0]         total;
	logic [TOT_W-1-(FRAC_BITS+DW-1):0] top_bits;
	logic                            in_range;
	dcct_pkg::result_t               res_next;
	logic                            done_q;
	dcct_pkg::result_t               result_q;

	assign total = TOT_W'(own_part) + TOT_W'(cross_part);
	// Everything above the kept window must repeat the sign bit.
	assign top_bits = total[TOT_W-1:FRAC_BITS+DW-1];
	assign in_range = (&top_bits) || !(|top_bits);

	always_comb begin
		if (in_range) begin
			res_next.convection = total[FRAC_BITS+DW-1:FRAC_BITS];
			res_next.saturated  = 1'b0;
		end else begin
			res_next.convection = total[TOT_W-1] ? RES_MIN : RES_MAX;
			res_next.saturated  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= own_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (own_ctl.valid) begin
			result_q <= res_next;
		end
	end

	assign done = done_q;
	assign result = result_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	a_axes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		own_ctl.valid == cross_ctl.valid)
		else $error("axis units out of step");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##PIPE_DEPTH done)
		else $error("accepted item produced no result on time");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturated) |->
			(result.convection == RES_MAX || result.convection == RES_MIN))
		else $error("saturated result not at a bound");

endmodule
